// ===== hw/rtl/mtd_pkg.sv =====
`default_nettype none

package mtd_pkg;

   localparam int MAX_CODE_LEN_DEF = 7;

   localparam logic [7:0] SPACE_CHAR = 8'd32;
   localparam logic [7:0] DOT_RESET  = 8'd46;
   localparam logic [7:0] DASH_RESET = 8'd45;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_SYMBOL = 2'd1,
      CMD_FLUSH  = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   localparam logic REG_DOT  = 1'b0;
   localparam logic REG_DASH = 1'b1;

   typedef struct packed {
      logic clear_en;
      logic ins_load;
      logic ins_run;
      logic path_move;
      logic path_dir;
      logic path_reset;
      logic run_clear;
      logic run_space;
      logic out_load;
      logic out_space;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic ins_done;
      logic len_ok;
      logic is_dot;
      logic is_dash;
      logic is_space;
      logic two_results;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/morse_tree_decoder_top.sv =====
// A space or flush request is accepted in IDLE; EMIT then loads the registered result
// once the output is free, and for a long space run SPACE then loads the extra space.
// No request is taken outside IDLE. Dot, dash, ignored and unused requests leave the
// controller in IDLE; a valid insert runs INSERT with one tree write a cycle.
// Reset: synchronous; the node memory is then cleared one entry a cycle, all
// 2^(MAX_CODE_LEN+1) entries (256 by default), with no request taken; CSR writes work.
`default_nettype none

module morse_tree_decoder_top #(
   parameter int MAX_CODE_LEN = mtd_pkg::MAX_CODE_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // letter, code_bits, code_length, symbol_byte, zero pad
   input  logic [1:0]  req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_char
   output logic [0:0]  rsp_tuser,   // not_found
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mtd_pkg::*;

   logic [7:0]    dot_ff, dot_in;
   logic [7:0]    dash_ff, dash_in;
   logic          csr_write;
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   logic          not_found;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      dot_in  = dot_ff;
      dash_in = dash_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_DOT:  dot_in  = csr_pwdata[7:0];
            REG_DASH: dash_in = csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
      unique case (csr_paddr[2])
         REG_DOT:  csr_prdata = {24'd0, dot_ff};
         REG_DASH: csr_prdata = {24'd0, dash_ff};
         default:  csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff  <= DOT_RESET;
         dash_ff <= DASH_RESET;
      end else begin
         dot_ff  <= dot_in;
         dash_ff <= dash_in;
      end
   end

   mtd_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   mtd_datapath #(
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .status          (dp_status),
      .dot_symbol      (dot_ff),
      .dash_symbol     (dash_ff),
      .req_letter      (req_tdata[7:0]),
      .req_code_bits   (req_tdata[14:8]),
      .req_code_length (req_tdata[17:15]),
      .req_symbol_byte (req_tdata[25:18]),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_out_char    (rsp_tdata),
      .rsp_not_found   (not_found),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tuser = not_found;

   a_err_zero_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 8'd0)
      else $error("error response carries a nonzero character");

   a_space_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |-> !req_tready)
      else $error("request taken before the trailing space response");

   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request accepted during node memory clear");

endmodule

`default_nettype wire

// ===== hw/rtl/mtd_datapath.sv =====
`default_nettype none

module mtd_datapath #(
   parameter int MAX_CODE_LEN = mtd_pkg::MAX_CODE_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mtd_pkg::dp_cmd_type   cmd,
   output mtd_pkg::dp_status_type status,
   input  logic [7:0]            dot_symbol,
   input  logic [7:0]            dash_symbol,
   input  logic [7:0]            req_letter,
   input  logic [6:0]            req_code_bits,
   input  logic [2:0]            req_code_length,
   input  logic [7:0]            req_symbol_byte,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [7:0]            rsp_out_char,
   output logic                  rsp_not_found,
   output logic                  rsp_last
);
   import mtd_pkg::*;

   localparam int NODE_W     = MAX_CODE_LEN + 1;
   localparam int NODE_COUNT = 1 << NODE_W;
   localparam int DEPTH_W    = $clog2(MAX_CODE_LEN + 1);

   logic [7:0]         letter_mem  [NODE_COUNT];
   logic               present_mem [NODE_COUNT];
   logic [7:0]         letter_rd_ff;
   logic               present_rd_ff;

   logic [NODE_W-1:0]  clr_ff, clr_in;
   logic [NODE_W-1:0]  path_idx_ff, path_idx_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               overflow_ff, overflow_in;
   logic [1:0]         space_run_ff, space_run_in;

   logic [NODE_W-1:0]  ins_idx_ff, ins_idx_in;
   logic [2:0]         ins_cnt_ff, ins_cnt_in;
   logic [2:0]         ins_len_ff, ins_len_in;
   logic [6:0]         ins_bits_ff, ins_bits_in;
   logic [7:0]         ins_letter_ff, ins_letter_in;
   logic [NODE_W-1:0]  ins_idx_next;
   logic               ins_done;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_char_ff, rsp_char_in;
   logic               rsp_nf_ff, rsp_nf_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               node_missing;

   assign ins_idx_next = {ins_idx_ff[NODE_W-2:0], ins_bits_ff[ins_cnt_ff]};
   assign ins_done     = (ins_cnt_ff == ins_len_ff);
   assign node_missing = overflow_ff | ~present_rd_ff;

   always_comb begin
      status.clr_done    = (clr_ff == {NODE_W{1'b1}});
      status.ins_done    = ins_done;
      status.len_ok      = (int'(req_code_length) <= MAX_CODE_LEN);
      status.is_dot      = (req_symbol_byte == dot_symbol);
      status.is_dash     = (req_symbol_byte == dash_symbol);
      status.is_space    = (req_symbol_byte == SPACE_CHAR);
      status.two_results = (space_run_ff == 2'd3);
      status.out_free    = ~rsp_valid_ff | rsp_tready;
   end

   // node memories
   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         letter_mem[clr_ff] <= SPACE_CHAR;
      end else if (cmd.ins_run && ins_done) begin
         letter_mem[ins_idx_ff] <= ins_letter_ff;
      end
      letter_rd_ff <= letter_mem[path_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         present_mem[clr_ff] <= (clr_ff == NODE_W'(1));
      end else if (cmd.ins_run && !ins_done) begin
         present_mem[ins_idx_next] <= 1'b1;
      end
      present_rd_ff <= present_mem[path_idx_ff];
   end

   always_comb begin
      clr_in = clr_ff;
      if (cmd.clear_en) begin
         clr_in = clr_ff + NODE_W'(1);
      end

      path_idx_in = path_idx_ff;
      depth_in    = depth_ff;
      overflow_in = overflow_ff;
      if (cmd.path_reset) begin
         path_idx_in = NODE_W'(1);
         depth_in    = '0;
         overflow_in = 1'b0;
      end else if (cmd.path_move) begin
         if (depth_ff >= DEPTH_W'(MAX_CODE_LEN)) begin
            overflow_in = 1'b1;
         end else begin
            path_idx_in = {path_idx_ff[NODE_W-2:0], cmd.path_dir};
            depth_in    = depth_ff + DEPTH_W'(1);
         end
      end

      space_run_in = space_run_ff;
      if (cmd.run_clear) begin
         space_run_in = 2'd0;
      end else if (cmd.run_space && space_run_ff != 2'd3) begin
         space_run_in = space_run_ff + 2'd1;
      end

      ins_idx_in    = ins_idx_ff;
      ins_cnt_in    = ins_cnt_ff;
      ins_len_in    = ins_len_ff;
      ins_bits_in   = ins_bits_ff;
      ins_letter_in = ins_letter_ff;
      if (cmd.ins_load) begin
         ins_idx_in    = NODE_W'(1);
         ins_cnt_in    = 3'd0;
         ins_len_in    = req_code_length;
         ins_bits_in   = req_code_bits;
         ins_letter_in = req_letter;
      end else if (cmd.ins_run && !ins_done) begin
         ins_idx_in = ins_idx_next;
         ins_cnt_in = ins_cnt_ff + 3'd1;
      end

      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_nf_in    = rsp_nf_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = node_missing ? 8'd0 : letter_rd_ff;
         rsp_nf_in    = node_missing;
         rsp_last_in  = (space_run_ff != 2'd3);
      end else if (cmd.out_space) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = SPACE_CHAR;
         rsp_nf_in    = 1'b0;
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         path_idx_ff  <= NODE_W'(1);
         depth_ff     <= '0;
         overflow_ff  <= 1'b0;
         space_run_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         path_idx_ff  <= path_idx_in;
         depth_ff     <= depth_in;
         overflow_ff  <= overflow_in;
         space_run_ff <= space_run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ins_idx_ff    <= ins_idx_in;
      ins_cnt_ff    <= ins_cnt_in;
      ins_len_ff    <= ins_len_in;
      ins_bits_ff   <= ins_bits_in;
      ins_letter_ff <= ins_letter_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_nf_ff     <= rsp_nf_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_not_found = rsp_nf_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/mtd_controller.sv =====
`default_nettype none

module mtd_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic [1:0]             req_cmd,
   output logic                   req_tready,
   input  mtd_pkg::dp_status_type status,
   output mtd_pkg::dp_cmd_type    cmd
);
   import mtd_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_INSERT = 5'b00100,
      ST_EMIT   = 5'b01000,
      ST_SPACE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tready & req_tvalid;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_INSERT: begin
                     if (status.len_ok) begin
                        cmd.ins_load = 1'b1;
                        state_in     = ST_INSERT;
                     end
                  end
                  CMD_SYMBOL: begin
                     priority if (status.is_dot) begin
                        cmd.path_move = 1'b1;
                        cmd.run_clear = 1'b1;
                     end else if (status.is_dash) begin
                        cmd.path_move = 1'b1;
                        cmd.path_dir  = 1'b1;
                        cmd.run_clear = 1'b1;
                     end else if (status.is_space) begin
                        cmd.run_space = 1'b1;
                        state_in      = ST_EMIT;
                     end else begin
                        cmd.run_clear = 1'b1;
                     end
                  end
                  CMD_FLUSH: begin
                     cmd.run_clear = 1'b1;
                     state_in      = ST_EMIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INSERT: begin
            cmd.ins_run = 1'b1;
            if (status.ins_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.path_reset = 1'b1;
               state_in       = status.two_results ? ST_SPACE : ST_IDLE;
            end
         end
         ST_SPACE: begin
            if (status.out_free) begin
               cmd.out_space = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mtd_pkg::*;

   localparam int MAX_LEN     = MAX_CODE_LEN_DEF;
   localparam int NODES       = 1 << (MAX_LEN + 1);
   localparam int IDLE_TAIL   = 12;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_ITEMS = 65;

   typedef struct packed {
      logic [7:0] out_char;
      logic       not_found;
      logic       last;
   } letter_rsp_type;

   typedef struct packed {
      logic           is_csr;
      logic           reg_sel;
      logic [7:0]     reg_val;
      cmd_type        cmd;
      logic [7:0]     letter;
      logic [6:0]     bits;
      logic [2:0]     len;
      logic [7:0]     sym;
      logic [3:0]     reps;
      logic           typed;
      letter_rsp_type typed_rsp;
   } script_row_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   morse_tree_decoder_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // decoder shadow state
   logic [7:0]  tree_letter [NODES];
   logic        tree_present[NODES];
   logic [7:0]  walk_index;
   int          walk_depth;
   logic        walk_overflow;
   int          space_count;
   logic [7:0]  cfg_dot  = DOT_RESET;
   logic [7:0]  cfg_dash = DASH_RESET;

   letter_rsp_type pending_letters[$];
   script_row_type script[$];

   int  error_count   = 0;
   int  request_count = 0;
   int  useful_count  = 0;
   int  insert_count  = 0;
   int  flush_count   = 0;
   int  result_count  = 0;
   int  setting_count = 0;
   int  cycle_count   = 0;
   bit  quiet         = 1'b0;

   function automatic letter_rsp_type current_letter(input logic last);
      letter_rsp_type r;
      if (walk_overflow || !tree_present[walk_index])
         r = '{out_char: 8'd0, not_found: 1'b1, last: last};
      else
         r = '{out_char: tree_letter[walk_index], not_found: 1'b0, last: last};
      return r;
   endfunction

   task automatic home_walk();
      walk_index    = 8'd1;
      walk_depth    = 0;
      walk_overflow = 1'b0;
   endtask

   task automatic step_walk(input logic dir);
      if (walk_depth >= MAX_LEN) begin
         walk_overflow = 1'b1;
      end else begin
         walk_index = {walk_index[6:0], dir};
         walk_depth++;
      end
   endtask

   // advances the shadow decoder; queues the letters it owes when keep is set
   task automatic decode_request(input cmd_type cmd, input logic [7:0] letter,
                                 input logic [6:0] bits, input logic [2:0] len,
                                 input logic [7:0] sym, input bit keep,
                                 output bit effective);
      logic [7:0] idx;
      letter_rsp_type first;
      int n;
      n = 0;
      effective = 1'b1;
      first = '0;
      case (cmd)
         CMD_INSERT: begin
            if (len <= MAX_LEN) begin
               idx = 8'd1;
               for (int k = 0; k < len; k++) begin
                  idx = {idx[6:0], bits[k]};
                  tree_present[idx] = 1'b1;
               end
               tree_letter[idx] = letter;
            end
         end
         CMD_FLUSH: begin
            first = current_letter(1'b1);
            n = 1;
            home_walk();
            space_count = 0;
         end
         CMD_SYMBOL: begin
            if (sym == cfg_dot) begin
               space_count = 0;
               step_walk(1'b0);
            end else if (sym == cfg_dash) begin
               space_count = 0;
               step_walk(1'b1);
            end else if (sym == SPACE_CHAR) begin
               if (space_count < 3)
                  space_count++;
               if (space_count >= 3) begin
                  first = current_letter(1'b0);
                  n = 2;
               end else begin
                  first = current_letter(1'b1);
                  n = 1;
               end
               home_walk();
            end else begin
               space_count = 0;
               effective = 1'b0;
            end
         end
         default: effective = 1'b0;
      endcase
      if (keep && n > 0)
         pending_letters.push_back(first);
      if (keep && n > 1)
         pending_letters.push_back('{out_char: SPACE_CHAR, not_found: 1'b0, last: 1'b1});
   endtask

   task automatic send_request(input cmd_type cmd, input logic [7:0] letter,
                               input logic [6:0] bits, input logic [2:0] len,
                               input logic [7:0] sym, input bit typed,
                               input letter_rsp_type typed_rsp);
      bit effective;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'd0, sym, len, bits, letter};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      decode_request(cmd, letter, bits, len, sym, !typed, effective);
      if (typed)
         pending_letters.push_back(typed_rsp);
      request_count++;
      if (effective)
         useful_count++;
      if (cmd == CMD_INSERT)
         insert_count++;
      if (cmd == CMD_FLUSH)
         flush_count++;
      if (!quiet && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic send_symbol(input logic [7:0] sym);
      send_request(CMD_SYMBOL, 8'($urandom), 7'($urandom), 3'($urandom), sym, 1'b0, '0);
   endtask

   task automatic send_insert(input logic [7:0] letter, input logic [6:0] bits,
                              input logic [2:0] len);
      send_request(CMD_INSERT, letter, bits, len, 8'($urandom), 1'b0, '0);
   endtask

   task automatic send_flush();
      send_request(CMD_FLUSH, 8'($urandom), 7'($urandom), 3'($urandom), 8'($urandom),
                   1'b0, '0);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_letters.size() != 0)
         @(posedge clock);
      repeat (IDLE_TAIL) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [7:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'd0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (idx == REG_DOT)
         cfg_dot = val;
      else if (idx == REG_DASH)
         cfg_dash = val;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (csr_prdata[7:0] !== val) begin
         $display("%0t: register %0d readback expected %h actual %h",
                  $time, idx, val, csr_prdata[7:0]);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      setting_count++;
   endtask

   task automatic set_symbols(input logic [7:0] dot, input logic [7:0] dash);
      wait_idle();
      write_register(REG_DOT, dot);
      write_register(REG_DASH, dash);
   endtask

   function automatic script_row_type req_row(input cmd_type cmd, input logic [7:0] letter,
                                              input logic [6:0] bits, input logic [2:0] len,
                                              input logic [7:0] sym, input int reps);
      script_row_type r;
      r = '0;
      r.cmd    = cmd;
      r.letter = letter;
      r.bits   = bits;
      r.len    = len;
      r.sym    = sym;
      r.reps   = 4'(reps);
      return r;
   endfunction

   function automatic script_row_type flush_row(input letter_rsp_type want);
      script_row_type r;
      r = req_row(CMD_FLUSH, 8'd0, 7'd0, 3'd0, 8'd0, 1);
      r.typed     = 1'b1;
      r.typed_rsp = want;
      return r;
   endfunction

   function automatic script_row_type csr_row(input logic idx, input logic [7:0] val);
      script_row_type r;
      r = '0;
      r.is_csr  = 1'b1;
      r.reg_sel = idx;
      r.reg_val = val;
      return r;
   endfunction

   // random traffic: mostly coded words with spaces or flushes, some noise
   task automatic random_phase(input int target);
      int goal;
      int len;
      int pick;
      logic [9:0] code;
      goal = useful_count + target;
      while (useful_count < goal) begin
         quiet = (useful_count >= 200 && useful_count < 280);
         if ($urandom_range(99) < 12) begin
            pick = $urandom_range(3);
            case (pick)
               0: send_request(CMD_UNUSED, 8'($urandom), 7'($urandom), 3'($urandom),
                               8'($urandom), 1'b0, '0);
               1: send_symbol(8'($urandom));
               2: send_insert(8'($urandom), 7'($urandom), 3'($urandom));
               default: send_flush();
            endcase
         end else begin
            pick = $urandom_range(99);
            if (pick < 5)
               len = 0;
            else if (pick < 75)
               len = $urandom_range(1, 4);
            else if (pick < 93)
               len = $urandom_range(5, MAX_LEN);
            else
               len = $urandom_range(MAX_LEN + 1, MAX_LEN + 2);
            code = 10'($urandom);
            if (len <= MAX_LEN && $urandom_range(99) < 35)
               send_insert(8'($urandom), code[6:0], 3'(len));
            for (int k = 0; k < len; k++)
               send_symbol(code[k] ? cfg_dash : cfg_dot);
            pick = $urandom_range(99);
            if (pick < 65)
               repeat ($urandom_range(1, 4)) send_symbol(SPACE_CHAR);
            else if (pick < 85)
               send_flush();
         end
      end
      quiet = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 18);
   end

   always @(posedge clock) begin : check_results
      letter_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_letters.size() == 0) begin
            $display("%0t: unexpected result expected none actual char %h not_found %b last %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            error_count++;
         end else begin
            want = pending_letters.pop_front();
            result_count++;
            if (rsp_tdata !== want.out_char) begin
               $display("%0t: out_char expected %h actual %h", $time, want.out_char, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser[0] !== want.not_found) begin
               $display("%0t: not_found expected %b actual %b",
                        $time, want.not_found, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_letters.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NODES; i++) begin
         tree_letter[i]  = SPACE_CHAR;
         tree_present[i] = 1'b0;
      end
      tree_present[1] = 1'b1;
      home_walk();
      space_count = 0;

      // reset-state reads, tree build, long space runs, depth limit, symbol remaps
      script.push_back(flush_row('{out_char: SPACE_CHAR, not_found: 1'b0, last: 1'b1}));
      script.push_back(req_row(CMD_SYMBOL, 8'd0, 7'd0, 3'd0, DOT_RESET, 1));
      script.push_back(flush_row('{out_char: 8'd0, not_found: 1'b1, last: 1'b1}));
      script.push_back(req_row(CMD_SYMBOL, 8'hFF, 7'h7F, 3'd7, SPACE_CHAR, 1));
      script.push_back(req_row(CMD_INSERT, "E", 7'h00, 3'd1, 8'd0, 1));
      script.push_back(req_row(CMD_INSERT, "T", 7'h01, 3'd1, 8'd0, 1));
      script.push_back(req_row(CMD_INSERT, 8'hFF, 7'h7F, 3'd0, 8'hFF, 1));
      script.push_back(req_row(CMD_INSERT, "A", 7'h02, 3'd2, 8'd0, 1));
      script.push_back(req_row(CMD_INSERT, 8'h00, 7'h7F, 3'd7, 8'd0, 1));
      script.push_back(req_row(CMD_INSERT, "Z", 7'h00, 3'd7, 8'd0, 1));
      script.push_back(req_row(CMD_SYMBOL, 8'd0, 7'd0, 3'd0, DOT_RESET, 1));
      script.push_back(req_row(CMD_SYMBOL, 8'd0, 7'd0, 3'd0, DASH_RESET, 1));
      script.push_back(req_row(CMD_SYMBOL, 8'd0, 7'd0, 3'd0, SPACE_CHAR, 4));
      script.push_back(req_row(CMD_SYMBOL, 8'd0, 7'd0, 3'd0, 8'h00, 1));
      script.push_back(req_row(CMD_SYMBOL, 8'd0, 7'd0, 3'd0, 8'hFF, 1));
      script.push_back(req_row(CMD_SYMBOL, 8'd0, 7'd0, 3'd0, DASH_RESET, 7));
      script.push_back(req_row(CMD_SYMBOL, 8'd0, 7'd0, 3'd0, SPACE_CHAR, 1));
      script.push_back(req_row(CMD_SYMBOL, 8'd0, 7'd0, 3'd0, DASH_RESET, 8));
      script.push_back(flush_row('{out_char: 8'd0, not_found: 1'b1, last: 1'b1}));
      script.push_back(req_row(CMD_UNUSED, 8'hFF, 7'h7F, 3'd7, 8'hFF, 1));
      script.push_back(csr_row(REG_DOT, SPACE_CHAR));
      script.push_back(csr_row(REG_DASH, SPACE_CHAR));
      script.push_back(req_row(CMD_SYMBOL, 8'd0, 7'd0, 3'd0, SPACE_CHAR, 1));
      script.push_back(req_row(CMD_FLUSH, 8'd0, 7'd0, 3'd0, 8'd0, 1));
      script.push_back(csr_row(REG_DOT, 8'h00));
      script.push_back(csr_row(REG_DASH, 8'hFF));
      script.push_back(req_row(CMD_SYMBOL, 8'd0, 7'd0, 3'd0, 8'h00, 1));
      script.push_back(req_row(CMD_SYMBOL, 8'd0, 7'd0, 3'd0, 8'hFF, 1));
      script.push_back(req_row(CMD_SYMBOL, 8'd0, 7'd0, 3'd0, SPACE_CHAR, 1));
      script.push_back(req_row(CMD_FLUSH, 8'd0, 7'd0, 3'd0, 8'd0, 1));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            wait_idle();
            write_register(script[i].reg_sel, script[i].reg_val);
         end else begin
            repeat (script[i].reps)
               send_request(script[i].cmd, script[i].letter, script[i].bits, script[i].len,
                            script[i].sym, script[i].typed, script[i].typed_rsp);
         end
      end

      set_symbols(DOT_RESET, DASH_RESET);
      random_phase(PHASE_ITEMS);
      set_symbols(8'($urandom), 8'($urandom));
      random_phase(PHASE_ITEMS);
      set_symbols(8'h00, 8'hFF);
      random_phase(PHASE_ITEMS);
      set_symbols(8'hFF, 8'h00);
      random_phase(PHASE_ITEMS);
      begin : equal_symbols
         logic [7:0] same;
         same = 8'($urandom);
         set_symbols(same, same);
      end
      random_phase(40);
      set_symbols(SPACE_CHAR, DASH_RESET);
      random_phase(40);
      set_symbols(DOT_RESET, DASH_RESET);
      random_phase(PHASE_ITEMS);
      wait_idle();

      $display("Sent %0d requests (%0d inserts, %0d flushes) under %0d register writes;",
               request_count, insert_count, flush_count, setting_count);
      $display("checked %0d decoded letters and error flags.", result_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
